>>> sv/h2r_pkg.sv
// ============================================================================
// h2r_pkg
// Shared types, constants and derived widths for the HSV to RGB converter.
// ============================================================================
package h2r_pkg;

   // Fixed-point scaling of hue and channel resolution.
   localparam int HUE_FRAC_BITS = 6;
   localparam int CHANNEL_BITS  = 8;

   // Input field widths.
   localparam int HUE_W = 15;
   localparam int IN_W  = 8;
   localparam int CH_W  = CHANNEL_BITS;

   // Full-scale channel value and hue angles in fixed-point units.
   localparam int CH_MAX     = (1 << CH_W) - 1;
   localparam int SECT_UNITS = 60 << HUE_FRAC_BITS;
   localparam int FULL_TURN  = 360 << HUE_FRAC_BITS;

   // Hue after reduction to one turn, and the working width for that reduction.
   localparam int HR_W = $clog2(FULL_TURN);
   localparam int HX_W = (HUE_W > HR_W) ? HUE_W : HR_W;

   // Position within a sextant, 0 to SECT_UNITS inclusive.
   localparam int T_W = $clog2(SECT_UNITS + 1);

   // Numerator s*t + (M-s)*U never exceeds M*U.
   localparam int NUM_W = $clog2(CH_MAX * SECT_UNITS + 1);

   // Product V*(M-S) and its reciprocal division by M.
   localparam int     VM_W    = 2 * CH_W;
   localparam int     MM_SH   = VM_W + $clog2(CH_MAX);
   localparam longint MM_K    = ((64'd1 << MM_SH) + CH_MAX - 1) / CH_MAX;
   localparam int     MM_K_W  = $clog2(MM_K + 1);
   localparam int     MMS_W   = VM_W + MM_K_W;

   // The divisor U*M splits into a power of two and 15*M.
   localparam int     Q_SH    = HUE_FRAC_BITS + 2;
   localparam int     VN_W    = CH_W + NUM_W;
   localparam int     Q_W     = VN_W - Q_SH;
   localparam int     XX_DIV  = 15 * CH_MAX;
   localparam int     XX_SH   = Q_W + $clog2(XX_DIV);
   localparam longint XX_K    = ((64'd1 << XX_SH) + XX_DIV - 1) / XX_DIV;
   localparam int     XX_K_W  = $clog2(XX_K + 1);
   localparam int     XXS_W   = Q_W + XX_K_W;

   // Sixty-degree sectors of the hue circle.
   typedef enum logic [2:0] {
      SEXT_RY = 3'd0,   // red towards yellow
      SEXT_YG = 3'd1,   // yellow towards green
      SEXT_GC = 3'd2,   // green towards cyan
      SEXT_CB = 3'd3,   // cyan towards blue
      SEXT_BM = 3'd4,   // blue towards magenta
      SEXT_MR = 3'd5    // magenta towards red
   } h2r_sextant_type;

   // Input and output transactions.
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [IN_W-1:0]  saturation;
      logic [IN_W-1:0]  brightness;
   } h2r_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } h2r_rsp_type;

   // Hand-off from the sector stage to the arithmetic pipeline.
   typedef struct packed {
      h2r_sextant_type sextant;
      logic [T_W-1:0]  frac;
      logic [CH_W-1:0] sat;
      logic [CH_W-1:0] val;
   } h2r_sect_type;

   // Channel levels produced by the arithmetic pipeline.
   typedef struct packed {
      h2r_sextant_type sextant;
      logic [CH_W-1:0] val;
      logic [CH_W-1:0] xx;
      logic [CH_W-1:0] mm;
   } h2r_level_type;

endpackage

>>> sv/h2r_sector_stage.sv
// ============================================================================
// h2r_sector_stage
// Reduces the hue to one turn, finds its sextant and the distance term, and
// saturates the two fractions to full scale. One register stage.
// ============================================================================
module h2r_sector_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  h2r_pkg::h2r_req_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output h2r_pkg::h2r_sect_type out_data
);
   import h2r_pkg::*;

   logic            valid_ff;
   h2r_sect_type    data_ff;
   h2r_sect_type    data_in;
   logic            load;
   logic [HX_W-1:0] hue_ext;
   logic [HR_W-1:0] hue_red;
   logic [HR_W-1:0] offset;
   logic            odd;

   // Saturate an input fraction to full scale.
   function automatic logic [CH_W-1:0] clamp_chan(input logic [IN_W-1:0] x);
      if (32'(x) > CH_MAX) begin
         return CH_W'(CH_MAX);
      end
      return CH_W'(x);
   endfunction

   // Hue reduction and sextant decode.
   always_comb begin
      hue_ext = HX_W'(in_data.hue);
      if (hue_ext >= HX_W'(FULL_TURN)) begin
         hue_red = HR_W'(hue_ext - HX_W'(FULL_TURN));
      end else begin
         hue_red = HR_W'(hue_ext);
      end

      if (hue_red >= HR_W'(5 * SECT_UNITS)) begin
         data_in.sextant = SEXT_MR;
         offset          = hue_red - HR_W'(5 * SECT_UNITS);
         odd             = 1'b1;
      end else if (hue_red >= HR_W'(4 * SECT_UNITS)) begin
         data_in.sextant = SEXT_BM;
         offset          = hue_red - HR_W'(4 * SECT_UNITS);
         odd             = 1'b0;
      end else if (hue_red >= HR_W'(3 * SECT_UNITS)) begin
         data_in.sextant = SEXT_CB;
         offset          = hue_red - HR_W'(3 * SECT_UNITS);
         odd             = 1'b1;
      end else if (hue_red >= HR_W'(2 * SECT_UNITS)) begin
         data_in.sextant = SEXT_GC;
         offset          = hue_red - HR_W'(2 * SECT_UNITS);
         odd             = 1'b0;
      end else if (hue_red >= HR_W'(SECT_UNITS)) begin
         data_in.sextant = SEXT_YG;
         offset          = hue_red - HR_W'(SECT_UNITS);
         odd             = 1'b1;
      end else begin
         data_in.sextant = SEXT_RY;
         offset          = hue_red;
         odd             = 1'b0;
      end

      // Rising sextants use the offset directly; falling ones mirror it.
      if (odd) begin
         data_in.frac = T_W'(SECT_UNITS) - T_W'(offset);
      end else begin
         data_in.frac = T_W'(offset);
      end

      data_in.sat = clamp_chan(in_data.saturation);
      data_in.val = clamp_chan(in_data.brightness);
   end

   // The stage takes a new transaction when empty or when it is draining.
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> sv/h2r_arith_pipe.sv
// ============================================================================
// h2r_arith_pipe
// Four register stages that form the products of the conversion and divide
// them by their constant denominators through exact reciprocal multiplies.
// ============================================================================
module h2r_arith_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  h2r_pkg::h2r_sect_type  in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output h2r_pkg::h2r_level_type out_data
);
   import h2r_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] load;
   logic [STAGES-1:0] prev_valid;

   // Sextant and value travel alongside every stage.
   h2r_sextant_type   sext_ff [STAGES];
   logic [CH_W-1:0]   val_ff  [STAGES];

   // Stage one: partial products.
   logic [NUM_W-1:0]      st_ff, st_in;
   logic [NUM_W-1:0]      mu_ff, mu_in;
   logic [VM_W-1:0]       vm_ff, vm_in;
   logic [CH_W+T_W-1:0]   st_full;
   logic [CH_W-1:0]       inv_sat;

   // Stage two: numerator sum and scaled V*(M-S).
   logic [NUM_W-1:0]      num_ff, num_in;
   logic [MMS_W-1:0]      mms_ff, mms_in;

   // Stage three: full numerator with the power-of-two divisor removed.
   logic [VN_W-1:0]       vn_full;
   logic [Q_W-1:0]        q_ff, q_in;
   logic [CH_W-1:0]       mm_ff [2:3];
   logic [CH_W-1:0]       mm_in;

   // Stage four: scaled quotient for the x component.
   logic [XXS_W-1:0]      xxs_ff, xxs_in;

   // Stage loading: each stage advances when empty or when the next one does.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      prev_valid[0] = in_valid;
      for (int k = 1; k < STAGES; k++) begin
         prev_valid[k] = valid_ff[k-1];
      end
   end

   assign in_ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (load[k]) begin
               valid_ff[k] <= prev_valid[k];
            end
         end
      end
   end

   // Datapath arithmetic for each stage.
   always_comb begin
      inv_sat = CH_W'(CH_MAX) - in_data.sat;
      st_full = (CH_W + T_W)'(in_data.sat) * (CH_W + T_W)'(in_data.frac);
      st_in   = NUM_W'(st_full);
      mu_in   = NUM_W'(inv_sat) * NUM_W'(SECT_UNITS);
      vm_in   = VM_W'(in_data.val) * VM_W'(inv_sat);

      num_in  = st_ff + mu_ff;
      mms_in  = MMS_W'(vm_ff) * MMS_W'(MM_K);

      vn_full = VN_W'(val_ff[1]) * VN_W'(num_ff);
      q_in    = vn_full[VN_W-1:Q_SH];
      mm_in   = CH_W'(mms_ff >> MM_SH);

      xxs_in  = XXS_W'(q_ff) * XXS_W'(XX_K);
   end

   // Stage registers; payload only moves on a valid load.
   always_ff @(posedge clock) begin
      if (load[0] && prev_valid[0]) begin
         st_ff      <= st_in;
         mu_ff      <= mu_in;
         vm_ff      <= vm_in;
         sext_ff[0] <= in_data.sextant;
         val_ff[0]  <= in_data.val;
      end
      if (load[1] && prev_valid[1]) begin
         num_ff     <= num_in;
         mms_ff     <= mms_in;
         sext_ff[1] <= sext_ff[0];
         val_ff[1]  <= val_ff[0];
      end
      if (load[2] && prev_valid[2]) begin
         q_ff       <= q_in;
         mm_ff[2]   <= mm_in;
         sext_ff[2] <= sext_ff[1];
         val_ff[2]  <= val_ff[1];
      end
      if (load[3] && prev_valid[3]) begin
         xxs_ff     <= xxs_in;
         mm_ff[3]   <= mm_ff[2];
         sext_ff[3] <= sext_ff[2];
         val_ff[3]  <= val_ff[2];
      end
   end

   // Final quotient of the x component.
   always_comb begin
      out_data.sextant = sext_ff[STAGES-1];
      out_data.val     = val_ff[STAGES-1];
      out_data.xx      = CH_W'(xxs_ff >> XX_SH);
      out_data.mm      = mm_ff[3];
   end

   assign out_valid = valid_ff[STAGES-1];

   // The levels are ordered: m never exceeds x, and x never exceeds the value.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] |-> (out_data.mm <= out_data.xx && out_data.xx <= out_data.val))
      else $error("h2r_arith_pipe: channel levels out of order");

   // A transaction held at the last stage stays valid until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && !out_ready |=> valid_ff[STAGES-1])
      else $error("h2r_arith_pipe: stalled transaction was lost");

   // A blocked stage keeps its operands while it waits.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !load[1] |=> $stable(num_ff) && $stable(mms_ff))
      else $error("h2r_arith_pipe: blocked stage changed its operands");

endmodule

>>> sv/hsv_to_rgb_converter.sv
// ============================================================================
// hsv_to_rgb_converter
// Converts one HSV pixel to RGB channels per transaction in a six-stage
// pipeline: sector decode, four arithmetic stages and an output register.
// ============================================================================
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   hue, saturation, brightness
//   rsp_      out         rsp_valid/rsp_stall   red, green, blue
//
// One transaction is accepted per cycle while the pipeline is not held by a
// response stall; each result passes the sector register, the four arithmetic
// stages and the output register before it is presented. Reset clears only
// the stage valid bits. A stall on the response side holds every full stage
// in place and empty stages still fill, so req_stall rises only once the
// whole pipeline is occupied.
// ============================================================================
module hsv_to_rgb_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  h2r_pkg::h2r_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output h2r_pkg::h2r_rsp_type rsp_data
);
   import h2r_pkg::*;

   logic          sect_valid;
   logic          sect_ready;
   h2r_sect_type  sect_data;
   logic          level_valid;
   logic          level_ready;
   h2r_level_type level_data;
   logic          sector_in_ready;
   logic          rsp_valid_ff;
   h2r_rsp_type   rsp_data_ff;
   h2r_rsp_type   rsp_data_in;
   logic          out_load;

   // Sector decode stage.
   h2r_sector_stage u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (sector_in_ready),
      .in_data   (req_data),
      .out_valid (sect_valid),
      .out_ready (sect_ready),
      .out_data  (sect_data)
   );

   // Products and constant divisions.
   h2r_arith_pipe u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sect_valid),
      .in_ready  (sect_ready),
      .in_data   (sect_data),
      .out_valid (level_valid),
      .out_ready (level_ready),
      .out_data  (level_data)
   );

   assign req_stall = !sector_in_ready;

   // Route the three levels to the channels according to the sextant.
   always_comb begin
      unique case (level_data.sextant)
         SEXT_RY: begin
            rsp_data_in.red   = level_data.val;
            rsp_data_in.green = level_data.xx;
            rsp_data_in.blue  = level_data.mm;
         end
         SEXT_YG: begin
            rsp_data_in.red   = level_data.xx;
            rsp_data_in.green = level_data.val;
            rsp_data_in.blue  = level_data.mm;
         end
         SEXT_GC: begin
            rsp_data_in.red   = level_data.mm;
            rsp_data_in.green = level_data.val;
            rsp_data_in.blue  = level_data.xx;
         end
         SEXT_CB: begin
            rsp_data_in.red   = level_data.mm;
            rsp_data_in.green = level_data.xx;
            rsp_data_in.blue  = level_data.val;
         end
         SEXT_BM: begin
            rsp_data_in.red   = level_data.xx;
            rsp_data_in.green = level_data.mm;
            rsp_data_in.blue  = level_data.val;
         end
         default: begin
            rsp_data_in.red   = level_data.val;
            rsp_data_in.green = level_data.mm;
            rsp_data_in.blue  = level_data.xx;
         end
      endcase
   end

   // Output register: refills whenever it is empty or being taken.
   assign out_load    = !rsp_valid_ff || !rsp_stall;
   assign level_ready = out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= level_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && level_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sim/hsv_to_rgb_converter_tb.sv
// ============================================================================
// hsv_to_rgb_converter_tb
// Self-checking testbench for the HSV to RGB converter. Every accepted pixel
// is converted by an integer model held here and the expected colour is
// queued; each result transaction is compared field by field with the oldest
// queued colour. Directed corner pixels are followed by random traffic with
// random gaps and stalls on both sides, a full-rate stretch, and a long hold
// on the result side that backs the pipeline up into the request side.
// ============================================================================
module hsv_to_rgb_converter_tb;
   import h2r_pkg::*;

   localparam int IDLE_MAX       = 13;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int REPORT_MAX     = 10;

   // One accepted pixel together with the colour it must produce.
   typedef struct {
      h2r_req_type pixel;
      h2r_rsp_type rgb;
   } colour_entry_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   h2r_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   h2r_rsp_type rsp_data;

   colour_entry_type colour_queue[$];
   int               error_count   = 0;
   int               quiet_cycles  = 0;
   bit               req_idle_on   = 1'b1;
   bit               rsp_idle_on   = 1'b1;
   int               rsp_hold_len  = 0;

   hsv_to_rgb_converter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Integer HSV to RGB conversion: hue is folded into one turn, the sector
   // chooses the channel order, and every level is an exact floor.
   function automatic h2r_rsp_type convert_hsv(input h2r_req_type px);
      longint unsigned h, s, v, sector, p, dist_units, t, cc, xx, mm;
      h2r_sextant_type sext;
      h2r_rsp_type     rgb;
      h      = longint'(px.hue) % FULL_TURN;
      s      = px.saturation;
      v      = px.brightness;
      if (s > CH_MAX) s = CH_MAX;
      if (v > CH_MAX) v = CH_MAX;
      sector = h / SECT_UNITS;
      p      = h % (2 * SECT_UNITS);
      dist_units = (p >= SECT_UNITS) ? (p - SECT_UNITS) : (SECT_UNITS - p);
      t      = SECT_UNITS - dist_units;
      cc     = v;
      mm     = (v * (CH_MAX - s)) / CH_MAX;
      xx     = (v * (s * t + (CH_MAX - s) * SECT_UNITS)) / (SECT_UNITS * CH_MAX);
      sext   = h2r_sextant_type'(sector[2:0]);
      case (sext)
         SEXT_RY: begin
            rgb.red = cc[CH_W-1:0]; rgb.green = xx[CH_W-1:0]; rgb.blue = mm[CH_W-1:0];
         end
         SEXT_YG: begin
            rgb.red = xx[CH_W-1:0]; rgb.green = cc[CH_W-1:0]; rgb.blue = mm[CH_W-1:0];
         end
         SEXT_GC: begin
            rgb.red = mm[CH_W-1:0]; rgb.green = cc[CH_W-1:0]; rgb.blue = xx[CH_W-1:0];
         end
         SEXT_CB: begin
            rgb.red = mm[CH_W-1:0]; rgb.green = xx[CH_W-1:0]; rgb.blue = cc[CH_W-1:0];
         end
         SEXT_BM: begin
            rgb.red = xx[CH_W-1:0]; rgb.green = mm[CH_W-1:0]; rgb.blue = cc[CH_W-1:0];
         end
         default: begin
            rgb.red = cc[CH_W-1:0]; rgb.green = mm[CH_W-1:0]; rgb.blue = xx[CH_W-1:0];
         end
      endcase
      return rgb;
   endfunction

   function automatic h2r_req_type make_pixel(input int h, input int s, input int v);
      h2r_req_type px;
      px.hue        = h[HUE_W-1:0];
      px.saturation = s[IN_W-1:0];
      px.brightness = v[IN_W-1:0];
      return px;
   endfunction

   // Random pixel: mostly hues within one turn, some over the whole field,
   // and saturation and brightness weighted towards their extremes.
   function automatic h2r_req_type random_pixel();
      int h, s, v, pick;
      pick = $urandom_range(0, 99);
      h    = (pick < 85) ? $urandom_range(0, FULL_TURN - 1) : $urandom_range(0, 32767);
      pick = $urandom_range(0, 9);
      s    = (pick == 0) ? 0 : (pick == 1) ? CH_MAX : $urandom_range(0, 255);
      pick = $urandom_range(0, 9);
      v    = (pick == 0) ? 0 : (pick == 1) ? CH_MAX : $urandom_range(0, 255);
      return make_pixel(h, s, v);
   endfunction

   // Offers one pixel after a random gap and waits until it is taken. The
   // valid is left high on return so that back-to-back pixels keep it up.
   task automatic drive_pixel(input h2r_req_type px);
      int unsigned gap;
      colour_entry_type entry;
      gap = req_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      entry.pixel = px;
      entry.rgb   = convert_hsv(px);
      colour_queue.push_back(entry);
      @(negedge clock);
   endtask

   // Corner pixels: sector boundaries, hues of a full turn and beyond,
   // grey, black, full colour and alternating bit patterns.
   task automatic test_corner_pixels();
      drive_pixel(make_pixel(0,     255, 255));
      drive_pixel(make_pixel(1920,  255, 255));
      drive_pixel(make_pixel(3839,  255, 255));
      drive_pixel(make_pixel(3840,  255, 255));
      drive_pixel(make_pixel(7680,  255, 255));
      drive_pixel(make_pixel(11520, 255, 255));
      drive_pixel(make_pixel(15360, 255, 255));
      drive_pixel(make_pixel(19200, 255, 255));
      drive_pixel(make_pixel(23039, 255, 255));
      drive_pixel(make_pixel(23040, 255, 255));
      drive_pixel(make_pixel(23041, 85,  170));
      drive_pixel(make_pixel(32767, 255, 255));
      drive_pixel(make_pixel(5760,  200, 180));
      drive_pixel(make_pixel(9600,  128, 64));
      drive_pixel(make_pixel(13440, 1,   254));
      drive_pixel(make_pixel(17280, 254, 1));
      drive_pixel(make_pixel(21120, 255, 128));
      drive_pixel(make_pixel(1234,  0,   200));
      drive_pixel(make_pixel(20000, 0,   255));
      drive_pixel(make_pixel(5000,  255, 0));
      drive_pixel(make_pixel(0,     0,   0));
      drive_pixel(make_pixel(32767, 0,   0));
      drive_pixel(make_pixel(16384, 170, 85));
      drive_pixel(make_pixel(21845, 85,  170));
      drive_pixel(make_pixel(10922, 170, 85));
   endtask

   // Random pixels; every block of 150 redraws which sides insert gaps.
   task automatic test_random_pixels(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            req_idle_on = $urandom_range(0, 3) != 0;
            rsp_idle_on = $urandom_range(0, 3) != 0;
         end
         drive_pixel(random_pixel());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Back-to-back traffic with neither side idling.
   task automatic test_full_rate(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int i = 0; i < count; i++)
         drive_pixel(random_pixel());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // The result side holds off for a long stretch while pixels keep coming,
   // so the pipeline fills and the request side is stalled.
   task automatic test_output_hold(input int count);
      req_idle_on  = 1'b0;
      rsp_hold_len = 300;
      for (int i = 0; i < count; i++)
         drive_pixel(random_pixel());
      req_idle_on  = 1'b1;
   endtask

   // Result side: stalls for a random number of cycles before each
   // transaction, or for the requested hold when one is pending.
   initial begin
      int unsigned wait_cycles;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold_len != 0) begin
            wait_cycles  = rsp_hold_len;
            rsp_hold_len = 0;
         end else begin
            wait_cycles = rsp_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Result checking and the count of cycles without any transaction.
   always @(posedge clock) begin
      colour_entry_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (colour_queue.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("ERROR: unexpected result r=%0d g=%0d b=%0d",
                           rsp_data.red, rsp_data.green, rsp_data.blue);
            end else begin
               want = colour_queue.pop_front();
               if (rsp_data.red !== want.rgb.red || rsp_data.green !== want.rgb.green ||
                   rsp_data.blue !== want.rgb.blue) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display("ERROR: h=%0d s=%0d v=%0d expected %0d/%0d/%0d got %0d/%0d/%0d",
                              want.pixel.hue, want.pixel.saturation, want.pixel.brightness,
                              want.rgb.red, want.rgb.green, want.rgb.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end
         end
      end
   end

   // Watchdog: ends the run once the block has been stuck for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Simulation FAILED");
      $finish;
   end

   // Test sequence.
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_corner_pixels();
      test_random_pixels(1200);
      test_full_rate(300);
      test_output_hold(40);

      req_valid <= 1'b0;
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
sv/h2r_pkg.sv
sv/h2r_sector_stage.sv
sv/h2r_arith_pipe.sv
sv/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_tb.sv
